// ===== design/b64d_pkg.sv =====
package b64d_pkg;

    // bytes counted per message; the counter is one bit wider and saturates
    localparam int COUNT_BITS = 16;
    localparam int CntW       = COUNT_BITS + 1;
    // wide enough to compare the counter with 16-bit capacity and count values
    localparam int WideW      = ((CntW > 16) ? CntW : 16) + 2;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [1:0] OpChar    = 2'd0;
    localparam logic [1:0] OpCharEnd = 2'd1;
    localparam logic [1:0] OpEnd     = 2'd2;

    localparam logic [7:0] CharPad   = 8'h3D;  // '='
    localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
    localparam logic [7:0] CharSlash = 8'h2F;  // '/'

    typedef enum logic [1:0] {
        StOk       = 2'd0,
        StBadChar  = 2'd1,
        StBadLen   = 2'd2,
        StCapacity = 2'd3
    } t_status;

    // everything one accepted item produces: up to three bytes, then maybe a status
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nb;
        logic            has_st;
        t_status         st;
        logic [15:0]     cnt;
    } t_bundle;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QPtrW:0]    count;
    } t_q_stat;

    // bit 6 set: not a base64 alphabet character
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd64;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30 + 8'd52;
        end else if (c == CharPlus) begin
            t = 8'd62;
        end else if (c == CharSlash) begin
            t = 8'd63;
        end
        return t[6:0];
    endfunction

endpackage

// ===== design/b64d_front.sv =====
module b64d_front
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_in_char,
    input  logic [15:0] i_cap,
    output logic        o_wr,
    output t_bundle     o_bundle
);

    logic [17:0]     r_acc, n_acc;
    logic [1:0]      r_gp, n_gp;
    logic            r_pad2, n_pad2;
    logic            r_bad, n_bad;
    logic [CntW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_gp   <= '0;
            r_pad2 <= 1'b0;
            r_bad  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_acc  <= n_acc;
            r_gp   <= n_gp;
            r_pad2 <= n_pad2;
            r_bad  <= n_bad;
            r_cnt  <= n_cnt;
        end
    end

    logic            op_char, op_end, held_rel, pad, is_inv, sup_bad;
    logic [17:0]     acc_base;
    logic [6:0]      sx;
    logic [5:0]      s;
    logic [23:0]     v;
    logic [1:0]      p, nc, ne;
    logic [2:0][7:0] cand;
    logic [WideW-1:0] e_w, cap_w, diff_w, sum_w, en_w;
    t_status         st;

    always_comb begin
        op_char  = (i_op == OpChar) || (i_op == OpCharEnd);
        op_end   = (i_op != OpChar);
        held_rel = op_char && (r_gp == 2'd0) && (r_acc[17:16] != 2'd0);
        acc_base = held_rel ? 18'd0 : r_acc;
        sx       = sextet_of(i_in_char);
        pad      = (i_in_char == CharPad) && r_gp[1];
        is_inv   = !pad && sx[6];
        s        = (pad || sx[6]) ? 6'd0 : sx[5:0];
        v        = {acc_base, s};
        p        = {1'b0, r_pad2} + {1'b0, pad};

        n_acc  = r_acc;
        n_gp   = r_gp;
        n_pad2 = r_pad2;
        n_bad  = r_bad | (op_char & is_inv);
        cand   = '0;
        nc     = 2'd0;
        sup_bad = n_bad;

        if (held_rel) begin
            sup_bad = r_bad;
            if (r_acc[17:16] == 2'd2) begin
                cand[0] = r_acc[15:8];
                cand[1] = r_acc[7:0];
                nc      = 2'd2;
            end else begin
                cand[0] = r_acc[7:0];
                nc      = 2'd1;
            end
        end

        if (op_char) begin
            if (r_gp != 2'd3) begin
                n_acc = {acc_base[11:0], s};
                n_gp  = r_gp + 2'd1;
                if (pad && r_gp == 2'd2) begin
                    n_pad2 = 1'b1;
                end
            end else begin
                cand[0] = v[23:16];
                cand[1] = v[15:8];
                cand[2] = v[7:0];
                nc      = 2'd3 - p;
                // a padded group that may not be final holds back what it may still yield
                if (i_op == OpChar && p == 2'd2) begin
                    n_acc = {2'd2, v[15:0]};
                end else if (i_op == OpChar && p == 2'd1) begin
                    n_acc = {2'd1, 8'h00, v[7:0]};
                end else begin
                    n_acc = '0;
                end
                n_gp   = 2'd0;
                n_pad2 = 1'b0;
            end
        end

        // capacity keeps only a prefix of the candidate bytes
        e_w    = WideW'(r_cnt);
        cap_w  = WideW'(i_cap);
        diff_w = cap_w - e_w;
        if (sup_bad || e_w >= cap_w) begin
            ne = 2'd0;
        end else if (diff_w >= WideW'(nc)) begin
            ne = nc;
        end else begin
            ne = diff_w[1:0];
        end

        sum_w = e_w + WideW'(nc);
        if (sum_w > WideW'({CntW{1'b1}})) begin
            n_cnt = {CntW{1'b1}};
        end else begin
            n_cnt = sum_w[CntW-1:0];
        end
        en_w = WideW'(n_cnt);

        if (n_gp != 2'd0) begin
            st = StBadLen;
        end else if (en_w > cap_w) begin
            st = StCapacity;
        end else if (n_bad) begin
            st = StBadChar;
        end else begin
            st = StOk;
        end

        o_bundle.bytes  = cand;
        o_bundle.nb     = ne;
        o_bundle.has_st = op_end;
        o_bundle.st     = st;
        if (st == StBadLen) begin
            o_bundle.cnt = 16'd0;
        end else if (en_w > WideW'(16'hFFFF)) begin
            o_bundle.cnt = 16'hFFFF;
        end else begin
            o_bundle.cnt = en_w[15:0];
        end

        o_wr = i_accept && (op_end || ne != 2'd0);

        if (op_end) begin
            n_acc  = '0;
            n_gp   = 2'd0;
            n_pad2 = 1'b0;
            n_bad  = 1'b0;
            n_cnt  = '0;
        end
    end

endmodule

// ===== design/b64d_queue.sv =====
module b64d_queue
    import b64d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wdata,
    input  logic    i_rd,
    output t_bundle o_rdata,
    output t_q_stat o_stat
);

    t_bundle          r_mem [QDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QPtrW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QPtrW + 1)'(QDepth));

endmodule

// ===== design/b64d_back.sv =====
module b64d_back
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_bundle     i_q_rdata,
    output logic        o_q_rd,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_is_status,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count,
    output logic        o_last
);

    logic       r_busy;
    t_bundle    r_bun;
    logic [1:0] r_idx;

    logic [2:0] total;
    logic       is_st, last, adv, load;

    always_comb begin
        total = {1'b0, r_bun.nb} + {2'b00, r_bun.has_st};
        last  = (({1'b0, r_idx} + 3'd1) == total);
        is_st = (r_idx == r_bun.nb);
        adv   = r_busy && i_pop && last;
        load  = (!r_busy || adv) && !i_q_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (adv) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bun <= i_q_rdata;
        end
    end

    always_comb begin
        o_q_rd       = load;
        o_empty      = !r_busy;
        o_is_status  = is_st;
        o_last       = last;
        o_status     = is_st ? r_bun.st : StOk;
        o_byte_count = is_st ? r_bun.cnt : 16'd0;
        case (r_idx)
            2'd0:    o_out_byte = r_bun.bytes[0];
            2'd1:    o_out_byte = r_bun.bytes[1];
            2'd2:    o_out_byte = r_bun.bytes[2];
            default: o_out_byte = 8'h00;
        endcase
        if (is_st) begin
            o_out_byte = 8'h00;
        end
    end

endmodule

// ===== design/base64_stream_decoder_unit.sv =====
// Base64 stream decoder, at most one encoded character per input item.
// Input queue side: op and in_char, taken when push is high and full low.
// op 0 is a character, op 1 a character that ends the message, op 2 ends the
// message without a character. Every fourth character yields up to three
// decoded bytes; a message end adds one status item with the byte count.
// Result queue side: the oldest result sits on the ports while empty is low
// and leaves when pop is high; last marks the final result of an input item.
// Capacity is written through the cfg channel (always ready) between messages
// by the user; the block does not enforce it. Results are queued at the edge
// that accepts their item; the output serializer then loads them. Throughput:
// one input item per cycle while full is low; results leave at one per cycle
// while pop is high. A four-entry queue between the decode stage and the
// output serializer absorbs the difference; full rises only when the queue
// fills while the receiver stalls or lags. Reset clears the message state and
// the queue and sets capacity to 65535.
module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_in_char,
    output logic        empty,
    input  logic        pop,
    output logic        o_is_status,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_cap;
    logic        accept, q_wr, q_rd;
    t_bundle     q_wdata, q_rdata;
    t_q_stat     q_stat;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign full        = q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    b64d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (i_op),
        .i_in_char (i_in_char),
        .i_cap     (r_cap),
        .o_wr      (q_wr),
        .o_bundle  (q_wdata)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_stat.empty),
        .i_q_rdata    (q_rdata),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_is_status  (o_is_status),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_status) |-> o_last)
        else $error("status item not marked last");

    a_data_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_is_status) |-> (o_status == StOk && o_byte_count == 16'd0))
        else $error("data item carries status fields");

    a_queue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= (QPtrW + 1)'(QDepth))
        else $error("queue count out of range");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !q_wr)
        else $error("queue written while full");
`endif

endmodule
